@@ rtl/crkr_pkg.sv @@
// ----------------------------------------------------------------------------
// crkr_pkg
// Shared types, command codes and the identification ROM for the card
// reader keypad responder.
// ----------------------------------------------------------------------------
package crkr_pkg;

    localparam int IDX_W = 6;

    localparam logic [15:0] CMD_GET_INFO  = 16'h0002;
    localparam logic [15:0] CMD_ENGAGE    = 16'h0131;
    localparam logic [15:0] CMD_POLL      = 16'h0134;
    localparam logic [15:0] CMD_SLOT      = 16'h0135;
    localparam logic [15:0] CMD_NOP_0000  = 16'h0000;
    localparam logic [15:0] CMD_NOP_0003  = 16'h0003;
    localparam logic [15:0] CMD_NOP_0116  = 16'h0116;
    localparam logic [15:0] CMD_NOP_0120  = 16'h0120;
    localparam logic [15:0] CMD_NOP_0130  = 16'h0130;
    localparam logic [15:0] CMD_NOP_013A  = 16'h013A;
    localparam logic [15:0] CMD_NOP_0160  = 16'h0160;
    localparam logic [15:0] CMD_NOP_0161  = 16'h0161;
    localparam logic [15:0] CMD_NOP_0164  = 16'h0164;

    localparam logic [1:0] OP_PACKET  = 2'd0;
    localparam logic [1:0] OP_SWITCH  = 2'd1;
    localparam logic [1:0] OP_PRESS   = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    localparam logic [1:0] SCMD_NONE  = 2'd0;
    localparam logic [1:0] SCMD_CLOSE = 2'd1;
    localparam logic [1:0] SCMD_OPEN  = 2'd2;
    localparam logic [1:0] SCMD_EJECT = 2'd3;

    localparam logic [7:0] ST_NO_CARD   = 8'h01;
    localparam logic [7:0] ST_CARD      = 8'h02;
    localparam logic [7:0] ST_HELD      = 8'h30;
    localparam logic [7:0] ST_PRESENT   = 8'h10;
    localparam logic [7:0] ST_SENSOR    = 8'h03;
    localparam logic [3:0] EV_CNT_RESET = 4'h8;

    typedef enum logic [1:0] {
        KIND_INFO   = 2'd0,
        KIND_ZERO   = 2'd1,
        KIND_STATUS = 2'd2,
        KIND_BAD    = 2'd3
    } kind_t;

    // one queued response job
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  st0;
        logic [7:0]  st1;
        logic        present;
        logic [7:0]  ev;
        logic [15:0] keys;
    } job_t;

    function automatic logic [7:0] info_rom_byte(input logic [IDX_W-1:0] a);
        logic [7:0] b;
        unique case (a)
            6'd0:  b = 8'h03;
            6'd5:  b = 8'h01;
            6'd6:  b = 8'h04;
            6'd8:  b = 8'h49;
            6'd9:  b = 8'h43;
            6'd10: b = 8'h43;
            6'd11: b = 8'h41;
            6'd12: b = 8'h4F;
            6'd13: b = 8'h63;
            6'd14: b = 8'h74;
            6'd15: b = 8'h20;
            6'd16: b = 8'h32;
            6'd17: b = 8'h36;
            6'd18: b = 8'h20;
            6'd19: b = 8'h32;
            6'd20: b = 8'h30;
            6'd21: b = 8'h30;
            6'd22: b = 8'h35;
            6'd28: b = 8'h31;
            6'd29: b = 8'h33;
            6'd30: b = 8'h20;
            6'd31: b = 8'h3A;
            6'd32: b = 8'h20;
            6'd33: b = 8'h35;
            6'd34: b = 8'h35;
            6'd35: b = 8'h20;
            6'd36: b = 8'h3A;
            6'd37: b = 8'h20;
            6'd38: b = 8'h30;
            6'd39: b = 8'h33;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/crkr_front.sv @@
// ----------------------------------------------------------------------------
// crkr_front
// Accepts event items, updates slot and keypad state, and classifies host
// packets into response jobs for the queue.
// ----------------------------------------------------------------------------
module crkr_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [1:0]         s_op,
    input  logic [15:0]        s_code,
    input  logic               s_has_slot,
    input  logic [1:0]         s_slot_cmd,
    input  logic               s_switch,
    input  logic [15:0]        s_key_mask,
    output logic               push,
    output crkr_pkg::job_t     push_job,
    input  logic               q_full
);

    logic        present_reg, present_next;
    logic        sw_prev_reg, sw_prev_next;
    logic        accepting_reg, accepting_next;
    logic        held_reg, held_next;
    logic [15:0] keys_down_reg, keys_down_next;
    logic [15:0] keys_seen_reg, keys_seen_next;
    logic [3:0]  ev_cnt_reg, ev_cnt_next;

    logic        accept;
    logic        is_packet;
    logic        is_status;
    crkr_pkg::kind_t kind;
    logic        s_present, s_accepting, s_held;
    logic [15:0] fresh;
    logic        found;
    logic [3:0]  key_idx;
    logic [7:0]  ev_byte;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign is_packet = (s_op == crkr_pkg::OP_PACKET);

    always_comb begin
        unique case (s_code)
            crkr_pkg::CMD_GET_INFO: kind = crkr_pkg::KIND_INFO;
            crkr_pkg::CMD_ENGAGE,
            crkr_pkg::CMD_POLL,
            crkr_pkg::CMD_SLOT:     kind = crkr_pkg::KIND_STATUS;
            crkr_pkg::CMD_NOP_0000,
            crkr_pkg::CMD_NOP_0003,
            crkr_pkg::CMD_NOP_0116,
            crkr_pkg::CMD_NOP_0120,
            crkr_pkg::CMD_NOP_0130,
            crkr_pkg::CMD_NOP_013A,
            crkr_pkg::CMD_NOP_0160,
            crkr_pkg::CMD_NOP_0161,
            crkr_pkg::CMD_NOP_0164: kind = crkr_pkg::KIND_ZERO;
            default:                kind = crkr_pkg::KIND_BAD;
        endcase
    end

    assign is_status = (kind == crkr_pkg::KIND_STATUS);

    // slot command applies before the status is taken
    always_comb begin
        s_present   = present_reg;
        s_accepting = accepting_reg;
        s_held      = held_reg;
        if (s_code == crkr_pkg::CMD_SLOT && s_has_slot) begin
            unique case (s_slot_cmd)
                crkr_pkg::SCMD_CLOSE: s_accepting = 1'b0;
                crkr_pkg::SCMD_OPEN:  s_accepting = 1'b1;
                crkr_pkg::SCMD_EJECT: begin
                    s_accepting = 1'b0;
                    s_held      = 1'b0;
                    s_present   = 1'b0;
                end
                default: ;
            endcase
        end
        if (s_accepting && s_present) begin
            s_held = 1'b1;
        end
    end

    // lowest key newly down since the previous status
    assign fresh = keys_down_reg & ~keys_seen_reg;
    always_comb begin
        found   = 1'b0;
        key_idx = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (fresh[k]) begin
                found   = 1'b1;
                key_idx = 4'(k);
            end
        end
    end
    assign ev_byte = found ? {ev_cnt_reg, key_idx} : 8'h00;

    always_comb begin
        present_next   = present_reg;
        sw_prev_next   = sw_prev_reg;
        accepting_next = accepting_reg;
        held_next      = held_reg;
        keys_down_next = keys_down_reg;
        keys_seen_next = keys_seen_reg;
        ev_cnt_next    = ev_cnt_reg;
        if (accept) begin
            unique case (s_op)
                crkr_pkg::OP_SWITCH: begin
                    if (s_switch && !sw_prev_reg) begin
                        present_next = 1'b1;
                    end
                    sw_prev_next = s_switch;
                end
                crkr_pkg::OP_PRESS:   keys_down_next = keys_down_reg | s_key_mask;
                crkr_pkg::OP_RELEASE: keys_down_next = keys_down_reg & ~s_key_mask;
                crkr_pkg::OP_PACKET: begin
                    if (is_status) begin
                        present_next   = s_present;
                        accepting_next = s_accepting;
                        held_next      = s_held;
                        keys_seen_next = keys_down_reg;
                        if (found) begin
                            ev_cnt_next = (ev_cnt_reg + 4'd1) | 4'h8;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg   <= 1'b0;
            sw_prev_reg   <= 1'b0;
            accepting_reg <= 1'b0;
            held_reg      <= 1'b0;
            keys_down_reg <= '0;
            keys_seen_reg <= '0;
            ev_cnt_reg    <= crkr_pkg::EV_CNT_RESET;
        end else begin
            present_reg   <= present_next;
            sw_prev_reg   <= sw_prev_next;
            accepting_reg <= accepting_next;
            held_reg      <= held_next;
            keys_down_reg <= keys_down_next;
            keys_seen_reg <= keys_seen_next;
            ev_cnt_reg    <= ev_cnt_next;
        end
    end

    assign push              = accept && is_packet;
    assign push_job.kind     = kind;
    assign push_job.st0      = (s_present && s_code != crkr_pkg::CMD_ENGAGE) ?
                               crkr_pkg::ST_CARD : crkr_pkg::ST_NO_CARD;
    assign push_job.st1      = !s_present ? 8'h00 :
                               (s_held ? crkr_pkg::ST_HELD : crkr_pkg::ST_PRESENT);
    assign push_job.present  = s_present;
    assign push_job.ev       = ev_byte;
    assign push_job.keys     = keys_down_reg;

endmodule

@@ rtl/crkr_fifo.sv @@
// ----------------------------------------------------------------------------
// crkr_fifo
// Short job queue between the classifier and the response streamer.
// ----------------------------------------------------------------------------
module crkr_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  crkr_pkg::job_t push_job,
    input  logic           pop,
    output crkr_pkg::job_t pop_job,
    output logic           full,
    output logic           empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    crkr_pkg::job_t      mem_reg [DEPTH];
    logic [PW-1:0]       wr_reg, wr_next;
    logic [PW-1:0]       rd_reg, rd_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

@@ rtl/crkr_back.sv @@
// ----------------------------------------------------------------------------
// crkr_back
// Streams each queued job as response bytes, one per cycle while m_tready
// is high, through an output register.
// ----------------------------------------------------------------------------
module crkr_back #(
    parameter int INFO_BYTES   = 44,
    parameter int STATUS_BYTES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [63:0]                 card_uid,
    input  logic                        q_empty,
    input  crkr_pkg::job_t              q_job,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);

    localparam int IW = crkr_pkg::IDX_W;
    localparam logic [IW-1:0] INFO_LAST   = IW'(INFO_BYTES - 1);
    localparam logic [IW-1:0] STATUS_LAST = IW'(STATUS_BYTES - 1);

    logic              act_reg, act_next;
    crkr_pkg::job_t    job_reg;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              mv_reg, mv_next;
    logic [7:0]        byte_reg;
    logic [IW-1:0]     oidx_reg;
    logic              olast_reg;
    logic              obad_reg;

    logic              emit;
    logic              last_now;
    logic [IW-1:0]     last_idx;
    logic [7:0]        cur_byte;
    logic [2:0]        uid_pos;
    logic [IW-1:0]     uid_off;

    always_comb begin
        unique case (job_reg.kind)
            crkr_pkg::KIND_INFO:   last_idx = INFO_LAST;
            crkr_pkg::KIND_STATUS: last_idx = STATUS_LAST;
            default:               last_idx = '0;
        endcase
    end

    assign emit     = act_reg && (!mv_reg || m_tready);
    assign last_now = (idx_reg == last_idx);
    assign q_pop    = !q_empty && (!act_reg || (emit && last_now));

    // uid bytes sit at 2..9, top byte first
    assign uid_off = idx_reg - IW'(2);
    assign uid_pos = uid_off[2:0];

    always_comb begin
        cur_byte = 8'h00;
        unique case (job_reg.kind)
            crkr_pkg::KIND_INFO: cur_byte = crkr_pkg::info_rom_byte(idx_reg);
            crkr_pkg::KIND_STATUS: begin
                if (idx_reg == IW'(0)) begin
                    cur_byte = job_reg.st0;
                end else if (idx_reg == IW'(1)) begin
                    cur_byte = job_reg.st1;
                end else if (idx_reg >= IW'(2) && idx_reg <= IW'(9)) begin
                    cur_byte = job_reg.present ? card_uid[{~uid_pos, 3'b000} +: 8] : 8'h00;
                end else if (idx_reg == IW'(11)) begin
                    cur_byte = crkr_pkg::ST_SENSOR;
                end else if (idx_reg == IW'(12)) begin
                    cur_byte = job_reg.ev;
                end else if (idx_reg == IW'(14)) begin
                    cur_byte = job_reg.keys[15:8];
                end else if (idx_reg == IW'(15)) begin
                    cur_byte = job_reg.keys[7:0];
                end
            end
            default: cur_byte = 8'h00;
        endcase
    end

    always_comb begin
        act_next = act_reg;
        idx_next = idx_reg;
        if (q_pop) begin
            act_next = 1'b1;
            idx_next = '0;
        end else if (emit) begin
            act_next = !last_now;
            idx_next = idx_reg + IW'(1);
        end
        mv_next = emit ? 1'b1 : (m_tready ? 1'b0 : mv_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            idx_reg <= '0;
            mv_reg  <= 1'b0;
        end else begin
            act_reg <= act_next;
            idx_reg <= idx_next;
            mv_reg  <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
        if (emit) begin
            byte_reg  <= cur_byte;
            oidx_reg  <= idx_reg;
            olast_reg <= last_now;
            obad_reg  <= (job_reg.kind == crkr_pkg::KIND_BAD);
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {2'b00, oidx_reg, byte_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = obad_reg;

    a_first_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata[13:8] == '0)
        else $error("response does not restart at byte zero");

    a_bad_single_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata[7:0] == 8'h00 && m_tdata[13:8] == '0)
        else $error("unhandled response is not a single zero byte");

    a_index_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
            m_tdata[13:8] == $past(m_tdata[13:8]) + IW'(1))
        else $error("response byte index skipped");

    a_no_pop_mid_job: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && act_reg |-> emit && last_now)
        else $error("job taken while another is still streaming");

endmodule

@@ rtl/card_reader_keypad_responder.sv @@
// ----------------------------------------------------------------------------
// card_reader_keypad_responder
// Card reader with keypad: tracks slot and key events and answers host
// command packets with byte-wide response streams.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake            Payload
//  s_        in   s_tvalid/s_tready    tuser op; tdata code, slot, switch, keys
//  m_        out  m_tvalid/m_tready    tdata byte+index; tlast; tuser unhandled
//  cfg_      in   cfg_valid/cfg_ready  cfg_data card_uid (always ready)
//
//  Items are accepted in the cycle offered while the job queue has room; physical
//  events only update state. A packet's response streams one byte per cycle
//  while m_tready is high (44 for get-info, 16 for status, otherwise 1), so the
//  byte streamer sets the sustained packet rate. A packet passes the job queue
//  and the job register before its first byte reaches the output register. The
//  queue decouples input from output stalls until full. Reset (sync, active-low)
//  clears control state, not queue or data registers; card_uid resets to default.
// ----------------------------------------------------------------------------
module card_reader_keypad_responder #(
    parameter int INFO_BYTES   = 44,
    parameter int STATUS_BYTES = 16,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // code[15:0] has_slot_byte[16] slot_command[18:17]
                                   // switch_level[19] key_mask[35:20] zero[39:36]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // data_byte[7:0] byte_index[13:8] zero[15:14]
    output logic        m_tlast,
    output logic        m_tuser,   // unhandled[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);

    localparam logic [63:0] UID_RESET = 64'hE004010000000001;

    logic [63:0]    uid_reg;
    logic           push;
    crkr_pkg::job_t push_job;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    crkr_pkg::job_t q_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uid_reg <= UID_RESET;
        end else if (cfg_valid && cfg_ready) begin
            uid_reg <= cfg_data;
        end
    end

    crkr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_op       (s_tuser),
        .s_code     (s_tdata[15:0]),
        .s_has_slot (s_tdata[16]),
        .s_slot_cmd (s_tdata[18:17]),
        .s_switch   (s_tdata[19]),
        .s_key_mask (s_tdata[35:20]),
        .push       (push),
        .push_job   (push_job),
        .q_full     (q_full)
    );

    crkr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (q_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    crkr_back #(
        .INFO_BYTES   (INFO_BYTES),
        .STATUS_BYTES (STATUS_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .card_uid (uid_reg),
        .q_empty  (q_empty),
        .q_job    (q_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
